// ----- hw/rtl/set_assoc_cache_tag_policy_top_assert.svh -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy_top_assert.svh
// assertion macros for the cache directory top level
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_POLICY_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_POLICY_TOP_ASSERT_SVH

// same-cycle implication
`define SAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// shared types and constants of the set associative cache directory
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int LINE_COUNT_DEF = 1024;
    localparam int ADDR_BITS_DEF  = 32;
    localparam int IN_ADDR_W      = 32;
    localparam int AGE_W          = 10;
    localparam int CNT_W          = 32;
    localparam int LOG2_W         = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 5;

    localparam logic [4:0] BS_RST  = 5'd4;
    localparam logic [3:0] SET_RST = 4'd10;
    localparam logic [3:0] WAY_RST = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY   = 3'd0,
        CFG_PREFETCH = 3'd1,
        CFG_BLOCK    = 3'd2,
        CFG_SETS     = 3'd3,
        CFG_WAYS     = 3'd4
    } t_cfg_reg;

    // effective geometry after saturation
    typedef struct packed {
        logic              lru;
        logic [LOG2_W-1:0] bs;
        logic [LOG2_W-1:0] sl;
        logic [LOG2_W-1:0] wl;
    } t_geom;

    typedef struct packed {
        logic go;
        logic pf;
    } t_lk_req;

    typedef struct packed {
        logic idle;
        logic done;
        logic miss;
    } t_lk_rsp;

endpackage

// ----- hw/rtl/sac_line_mem.sv -----
// ----------------------------------------------------------------------------
// sac_line_mem
// line store: valid, tag and age per line, one write and one registered read
// ----------------------------------------------------------------------------
module sac_line_mem #(
    parameter int DEPTH = 1024,
    parameter int IW    = 10,
    parameter int DW    = 43
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sac_lookup.sv -----
// ----------------------------------------------------------------------------
// sac_lookup
// one directory lookup: set scan, then fill or age update, way by way
// ----------------------------------------------------------------------------
module sac_lookup import sac_pkg::*; #(
    parameter int LINE_COUNT = LINE_COUNT_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lk_req              i_req,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  t_geom                i_geom,
    output t_lk_rsp              o_rsp
);

    localparam int K  = $clog2(LINE_COUNT + 1) - 1;
    localparam int IW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int CW = K + 1;
    localparam int DW = 1 + ADDR_BITS + AGE_W;

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_SHIFT   = 10'b0000000100,
        S_INDEX   = 10'b0000001000,
        S_SCAN_RD = 10'b0000010000,
        S_SCAN_EV = 10'b0000100000,
        S_RESOLVE = 10'b0001000000,
        S_UPD_RD  = 10'b0010000000,
        S_UPD_EV  = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_clr;
    logic [ADDR_BITS-1:0] r_addr, r_blk, r_tag;
    logic                 r_pf;
    logic [IW-1:0]        r_base;
    logic [CW-1:0]        r_last, r_i, r_used, r_found, r_zero;
    logic [AGE_W-1:0]     r_fa, r_max;
    logic                 r_hit, r_empty, r_repl, r_miss;

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr, line_addr;
    logic [DW-1:0]        mem_wdata, mem_rdata;
    logic                 rd_valid;
    logic [ADDR_BITS-1:0] rd_tag;
    logic [AGE_W-1:0]     rd_age;

    assign line_addr = r_base + IW'(r_i);
    assign {rd_valid, rd_tag, rd_age} = mem_rdata;

    sac_line_mem #(
        .DEPTH (LINE_COUNT),
        .IW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (line_addr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = line_addr;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_RESOLVE: begin
                if (!r_hit && r_empty) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, r_tag,
                                 (r_used == '0) ? AGE_W'(0) : r_max + AGE_W'(1)};
                end
            end
            S_UPD_EV: begin
                if (r_repl) begin
                    mem_we = 1'b1;
                    if (r_i == r_zero) begin
                        mem_wdata = {1'b1, r_tag, r_max};
                    end else begin
                        mem_wdata = {1'b1, rd_tag, rd_age - AGE_W'(1)};
                    end
                end else if (r_i == r_found) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, rd_tag, r_max};
                end else if (rd_age > r_fa) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, rd_tag, rd_age - AGE_W'(1)};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr == IW'(LINE_COUNT - 1)) n_state = S_IDLE;
            S_IDLE:    if (i_req.go) n_state = S_SHIFT;
            S_SHIFT:   n_state = S_INDEX;
            S_INDEX:   n_state = S_SCAN_RD;
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (!rd_valid || r_i == r_last) n_state = S_RESOLVE;
                else                             n_state = S_SCAN_RD;
            end
            S_RESOLVE: begin
                if (r_hit) n_state = (i_geom.lru && !r_pf) ? S_UPD_RD : S_DONE;
                else       n_state = r_empty ? S_DONE : S_UPD_RD;
            end
            S_UPD_RD:  n_state = S_UPD_EV;
            S_UPD_EV:  n_state = (r_i == r_used - CW'(1)) ? S_DONE : S_UPD_RD;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    r_addr <= i_addr;
                    r_pf   <= i_req.pf;
                end
            end
            S_SHIFT: r_blk <= r_addr >> i_geom.bs;
            S_INDEX: begin
                r_tag   <= r_blk >> i_geom.sl;
                r_base  <= (IW'(r_blk) & ~({IW{1'b1}} << i_geom.sl)) << i_geom.wl;
                r_last  <= (CW'(1) << i_geom.wl) - CW'(1);
                r_i     <= '0;
                r_used  <= '0;
                r_found <= '0;
                r_zero  <= '0;
                r_fa    <= '0;
                r_max   <= '0;
                r_hit   <= 1'b0;
                r_empty <= 1'b0;
            end
            S_SCAN_EV: begin
                if (!rd_valid) begin
                    r_empty <= 1'b1;
                end else begin
                    r_used <= r_used + CW'(1);
                    if (rd_age == '0) r_zero <= r_i;
                    if (rd_age > r_max) r_max <= rd_age;
                    // the highest matching way wins
                    if (rd_tag == r_tag) begin
                        r_found <= r_i;
                        r_hit   <= 1'b1;
                        r_fa    <= rd_age;
                    end
                    if (r_i != r_last) r_i <= r_i + CW'(1);
                end
            end
            S_RESOLVE: begin
                r_i    <= '0;
                r_repl <= !r_hit;
                r_miss <= !r_hit;
            end
            S_UPD_EV: r_i <= r_i + CW'(1);
            default: ;
        endcase
    end

    assign o_rsp.idle = (r_state == S_IDLE);
    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.miss = r_miss;

endmodule

// ----- hw/rtl/set_assoc_cache_tag_policy_top.sv -----
// a lookup shifts, indexes, then reads and checks each way, stopping at the first empty
// way, and resolves; a demand lru hit or a full-set replacement then rereads and rewrites
// each used way to update ages. an access runs its demand lookup, a prefetch lookup on a
// miss when enabled, a result strobe, then idle; the line memory's single read port paces
// the way scan. reset clears counters and loads config defaults, then a clearing pass
// empties the line memory while busy stays high; results cannot be stalled
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy_top
// cache directory with fifo or lru replacement, next-line prefetch, counters
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_policy_top_assert.svh"

module set_assoc_cache_tag_policy_top import sac_pkg::*; #(
    parameter int LINE_COUNT = LINE_COUNT_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [IN_ADDR_W-1:0]  i_access_address,
    input  logic                  i_write_access,
    output logic                  o_done,
    output logic                  o_was_hit,
    output logic                  o_prefetch_fetched,
    output logic [CNT_W-1:0]      o_read_total,
    output logic [CNT_W-1:0]      o_write_total,
    output logic [CNT_W-1:0]      o_hit_total,
    output logic [CNT_W-1:0]      o_miss_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int K = $clog2(LINE_COUNT + 1) - 1;

    typedef enum logic [5:0] {
        T_IDLE = 6'b000001,
        T_DGO  = 6'b000010,
        T_DEM  = 6'b000100,
        T_PFGO = 6'b001000,
        T_PF   = 6'b010000,
        T_OUT  = 6'b100000
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    t_state               r_state, n_state;
    logic                 r_policy, r_pf_en;
    logic [4:0]           r_bs;
    logic [3:0]           r_set, r_way;
    t_geom                r_geom;
    logic [LOG2_W-1:0]    wl_eff, sl_room;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CNT_W-1:0]     r_reads, r_writes, r_hits, r_misses;
    logic                 r_was_hit, r_pf_fetched;
    logic                 accept;
    t_lk_req              lk_req;
    t_lk_rsp              lk_rsp;

    assign busy        = (r_state != T_IDLE) || !lk_rsp.idle;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // saturate ways first, then sets into what is left
    assign wl_eff  = (LOG2_W'(r_way) > LOG2_W'(K)) ? LOG2_W'(K) : LOG2_W'(r_way);
    assign sl_room = LOG2_W'(K) - wl_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_pf_en  <= 1'b0;
            r_bs     <= BS_RST;
            r_set    <= SET_RST;
            r_way    <= WAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POLICY:   r_policy <= i_cfg_data[0];
                CFG_PREFETCH: r_pf_en  <= i_cfg_data[0];
                CFG_BLOCK:    r_bs     <= i_cfg_data;
                CFG_SETS:     r_set    <= i_cfg_data[3:0];
                CFG_WAYS:     r_way    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom.lru <= r_policy;
        r_geom.bs  <= r_bs;
        r_geom.wl  <= wl_eff;
        r_geom.sl  <= (LOG2_W'(r_set) > sl_room) ? sl_room : LOG2_W'(r_set);
    end

    assign lk_req.go = (r_state == T_DGO) || (r_state == T_PFGO);
    assign lk_req.pf = (r_state == T_PFGO);

    sac_lookup #(
        .LINE_COUNT (LINE_COUNT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lk_req),
        .i_addr  (r_addr),
        .i_geom  (r_geom),
        .o_rsp   (lk_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: if (accept) n_state = T_DGO;
            T_DGO:  n_state = T_DEM;
            T_DEM: begin
                if (lk_rsp.done) n_state = (lk_rsp.miss && r_pf_en) ? T_PFGO : T_OUT;
            end
            T_PFGO: n_state = T_PF;
            T_PF:   if (lk_rsp.done) n_state = T_OUT;
            T_OUT:  n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_reads  <= '0;
            r_writes <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_state <= n_state;
            if (accept && i_write_access) begin
                r_writes <= sat_inc(r_writes);
            end
            if (r_state == T_DEM && lk_rsp.done) begin
                if (lk_rsp.miss) begin
                    r_misses <= sat_inc(r_misses);
                    r_reads  <= sat_inc(r_reads);
                end else begin
                    r_hits <= sat_inc(r_hits);
                end
            end
            if (r_state == T_PF && lk_rsp.done && lk_rsp.miss) begin
                r_reads <= sat_inc(r_reads);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr       <= ADDR_BITS'(i_access_address);
            r_pf_fetched <= 1'b0;
        end
        if (r_state == T_DEM && lk_rsp.done) begin
            r_was_hit <= !lk_rsp.miss;
            // next block, wrapping in the address width
            r_addr    <= r_addr + (ADDR_BITS'(1) << r_bs);
        end
        if (r_state == T_PF && lk_rsp.done) begin
            r_pf_fetched <= lk_rsp.miss;
        end
    end

    assign o_done             = (r_state == T_OUT);
    assign o_was_hit          = r_was_hit;
    assign o_prefetch_fetched = r_pf_fetched;
    assign o_read_total       = r_reads;
    assign o_write_total      = r_writes;
    assign o_hit_total        = r_hits;
    assign o_miss_total       = r_misses;

    `SAC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "busy low after accept")
    `SAC_ASSERT_NOW(a_hit_no_pf, i_clk, i_rst_n, o_done && o_was_hit, !o_prefetch_fetched, "pf on hit")
    `SAC_ASSERT_NEXT(a_hits_mono, i_clk, i_rst_n, 1'b1, r_hits >= $past(r_hits), "hit count fell")
    `SAC_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done && !busy, "strobe too long")

endmodule

// ----- tb/set_assoc_cache_tag_policy_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy_checker
// watches the access, result and register channels of the cache directory,
// keeps its own copy of the line store and counters, and compares every
// result strobe against the oldest predicted outcome
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_policy_checker import sac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [IN_ADDR_W-1:0]  i_access_address,
    input  logic                  i_write_access,
    input  logic                  o_done,
    input  logic                  o_was_hit,
    input  logic                  o_prefetch_fetched,
    input  logic [CNT_W-1:0]      o_read_total,
    input  logic [CNT_W-1:0]      o_write_total,
    input  logic [CNT_W-1:0]      o_hit_total,
    input  logic [CNT_W-1:0]      o_miss_total,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int LINES   = LINE_COUNT_DEF;
    localparam int LINES_K = $clog2(LINE_COUNT_DEF);

    typedef struct packed {
        logic             hit;
        logic             pf;
        logic [CNT_W-1:0] rd;
        logic [CNT_W-1:0] wr;
        logic [CNT_W-1:0] ht;
        logic [CNT_W-1:0] ms;
    } t_outcome;

    logic             line_vld [LINES];
    logic [31:0]      line_tg  [LINES];
    logic [AGE_W-1:0] line_ag  [LINES];
    logic             pol_lru, pf_on;
    logic [4:0]       blk_log2;
    logic [3:0]       sets_log2, ways_log2;
    logic [CNT_W-1:0] n_rd, n_wr, n_hit, n_miss;
    t_outcome         outcome_q[$];

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    // returns 1 on a miss, after filling the block
    function automatic bit directory_lookup(logic [31:0] addr, bit is_pf);
        int wl, sl, ways, base, found, empty, zero_way, used;
        logic [AGE_W-1:0] max_age, fa;
        logic [31:0] blk, tg;
        wl = (ways_log2 > LINES_K) ? LINES_K : ways_log2;
        sl = (sets_log2 > LINES_K - wl) ? LINES_K - wl : sets_log2;
        ways = 1 << wl;
        blk = addr >> blk_log2;
        tg = blk >> sl;
        base = (blk & ((32'd1 << sl) - 1)) << wl;
        found = ways; empty = ways; zero_way = 0; used = 0; max_age = 0;
        for (int i = 0; i < ways; i++) begin
            if (!line_vld[base+i]) begin
                empty = i;
                break;
            end
            used++;
            if (line_ag[base+i] == 0) zero_way = i;
            if (line_ag[base+i] > max_age) max_age = line_ag[base+i];
            if (line_tg[base+i] == tg) found = i;
        end
        if (found < ways) begin
            if (pol_lru && !is_pf) begin
                fa = line_ag[base+found];
                for (int i = 0; i < ways && line_vld[base+i]; i++)
                    if (line_ag[base+i] > fa) line_ag[base+i] = line_ag[base+i] - 1;
                line_ag[base+found] = max_age;
            end
            return 0;
        end
        n_rd = sat_inc(n_rd);
        if (empty < ways) begin
            line_vld[base+empty] = 1;
            line_tg[base+empty]  = tg;
            line_ag[base+empty]  = (used == 0) ? '0 : max_age + 1;
        end else begin
            for (int i = 0; i < ways; i++) begin
                if (i != zero_way) begin
                    line_ag[base+i] = line_ag[base+i] - 1;
                end else begin
                    line_tg[base+i] = tg;
                    line_ag[base+i] = max_age;
                end
            end
        end
        return 1;
    endfunction

    function automatic t_outcome predict_access(logic [31:0] addr, logic wr);
        t_outcome o;
        o.hit = !directory_lookup(addr, 0);
        o.pf  = 0;
        if (o.hit) begin
            n_hit = sat_inc(n_hit);
        end else begin
            n_miss = sat_inc(n_miss);
            if (pf_on) o.pf = directory_lookup(addr + (32'd1 << blk_log2), 1);
        end
        if (wr) n_wr = sat_inc(n_wr);
        o.rd = n_rd; o.wr = n_wr; o.ht = n_hit; o.ms = n_miss;
        return o;
    endfunction

    assign o_pending = outcome_q.size();

    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_vld[i] = 0;
                line_tg[i]  = '0;
                line_ag[i]  = '0;
            end
            pol_lru = 0; pf_on = 0;
            blk_log2 = BS_RST; sets_log2 = SET_RST; ways_log2 = WAY_RST;
            n_rd = 0; n_wr = 0; n_hit = 0; n_miss = 0;
            outcome_q.delete();
        end else begin
            if (o_done) begin
                if (outcome_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    $display("%0t: unexpected result strobe, nothing predicted", $time);
                end else begin
                    e = outcome_q.pop_front();
                    if ({o_was_hit, o_prefetch_fetched, o_read_total, o_write_total,
                         o_hit_total, o_miss_total} !== e) begin
                        o_fail_count <= o_fail_count + 1;
                        $display("%0t: result mismatch exp hit=%0d pf=%0d rd=%0d wr=%0d hit=%0d miss=%0d",
                                 $time, e.hit, e.pf, e.rd, e.wr, e.ht, e.ms);
                        $display("%0t:                  got hit=%0d pf=%0d rd=%0d wr=%0d hit=%0d miss=%0d",
                                 $time, o_was_hit, o_prefetch_fetched, o_read_total,
                                 o_write_total, o_hit_total, o_miss_total);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_POLICY:   pol_lru   = i_cfg_data[0];
                    CFG_PREFETCH: pf_on     = i_cfg_data[0];
                    CFG_BLOCK:    blk_log2  = i_cfg_data;
                    CFG_SETS:     sets_log2 = i_cfg_data[3:0];
                    CFG_WAYS:     ways_log2 = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                outcome_q.push_back(predict_access(i_access_address, i_write_access));
        end
    end

    initial o_fail_count = 0;

endmodule

// ----- tb/set_assoc_cache_tag_policy_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy_top_tb
// drives access streams through the cache directory under a series of
// replacement, prefetch and geometry settings, with directed corner
// addresses and pooled random addresses so that sets fill, hit and evict
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_policy_top_tb;
    import sac_pkg::*;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  start = 0;
    logic                  busy;
    logic [IN_ADDR_W-1:0]  i_access_address = '0;
    logic                  i_write_access = 0;
    logic                  o_done, o_was_hit, o_prefetch_fetched;
    logic [CNT_W-1:0]      o_read_total, o_write_total, o_hit_total, o_miss_total;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count, pending;
    logic [31:0]           addr_pool[16];
    bit                    idling_on;

    always #1 i_clk = ~i_clk;

    set_assoc_cache_tag_policy_top uut (.*);

    set_assoc_cache_tag_policy_checker u_chk (
        .*, .o_fail_count(fail_count), .o_pending(pending)
    );

    // valid stays high across back to back writes, the caller drops it
    task automatic reg_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // block idle before any register change
    task automatic drain;
        start <= 0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic setup(bit lru, bit pf, logic [4:0] bs, logic [3:0] sl, logic [3:0] wl);
        drain();
        reg_write(CFG_POLICY, {4'd0, lru});
        reg_write(CFG_PREFETCH, {4'd0, pf});
        reg_write(CFG_BLOCK, bs);
        reg_write(CFG_SETS, {1'b0, sl});
        reg_write(CFG_WAYS, {1'b0, wl});
        i_cfg_valid <= 0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
    endtask

    task automatic send_access(logic [31:0] a, logic wr);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1;
        i_access_address <= a;
        i_write_access <= wr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // mostly pooled addresses so lines get reused, some neighbours, some noise
    task automatic random_accesses(int n);
        logic [31:0] a;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                a = addr_pool[$urandom_range(0, 15)] ^ $urandom_range(0, 15);
            else if (r < 9)
                a = addr_pool[$urandom_range(0, 15)] + ($urandom_range(1, 8) << 4);
            else
                a = $urandom;
            send_access(a, $urandom_range(0, 1));
        end
    endtask

    initial begin
        idling_on = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        // clearing pass keeps busy high
        drain();

        // reset geometry, corner addresses
        send_access(32'h0000_0000, 0);
        send_access(32'h0000_0000, 1);
        send_access(32'hFFFF_FFFF, 1);
        send_access(32'hFFFF_FFF0, 0);
        send_access(32'h8000_0000, 0);
        send_access(32'h0000_4000, 1);
        send_access(32'h0000_0000, 0);
        send_access(32'h5555_5555, 1);
        send_access(32'hAAAA_AAAA, 0);

        // a single four-way set with lru and prefetch: wraps at the top of memory
        setup(1, 1, 5'd0, 4'd0, 4'd2);
        send_access(32'hFFFF_FFFF, 0);
        send_access(32'h0000_0000, 0);
        send_access(32'h0000_0004, 1);
        send_access(32'h0000_0001, 0);
        send_access(32'h0000_0002, 0);
        send_access(32'h0000_0003, 1);
        send_access(32'h0000_0001, 0);
        send_access(32'h0000_0009, 0);
        random_accesses(250);

        // wait for the pipeline to empty mid-stream
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        random_accesses(50);

        // geometry reinterpreted without a flush
        setup(0, 1, 5'd16, 4'd0, 4'd3);
        random_accesses(250);

        setup(1, 0, 5'd5, 4'd1, 4'd1);
        random_accesses(300);

        // oversized geometry saturates to a single fully associative set
        setup(0, 1, 5'd31, 4'd15, 4'd15);
        send_access(32'hFFFF_FFFF, 1);
        send_access(32'h7FFF_FFFF, 0);
        random_accesses(15);
        setup(1, 1, 5'd12, 4'd0, 4'd10);
        random_accesses(20);

        setup(1, 1, 5'd2, 4'd3, 4'd4);
        random_accesses(280);

        // no idling to the end
        setup(0, 0, 5'd1, 4'd6, 4'd2);
        idling_on = 0;
        random_accesses(280);

        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sac_pkg.sv
hw/rtl/sac_line_mem.sv
hw/rtl/sac_lookup.sv
hw/rtl/set_assoc_cache_tag_policy_top.sv
tb/set_assoc_cache_tag_policy_checker.sv
tb/set_assoc_cache_tag_policy_top_tb.sv
